// ----- rtl/core/iir3ax_pkg.sv -----
// Shared types, constants and the scale-and-saturate helper for the three-axis IIR filter.
package iir3ax_pkg;

    localparam int AXES           = 3;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 18;
    localparam int COEF_FRAC_BITS = 14;
    localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS       = PROD_BITS + 2;
    localparam int CFG_IDX_BITS   = 3;

    // Filter path select
    typedef enum logic [1:0] {
        MODE_BANDPASS = 2'd0,
        MODE_HP_ONLY  = 2'd1,
        MODE_LP_ONLY  = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODE  = 3'd0,
        REG_HP_B0 = 3'd1,
        REG_HP_B1 = 3'd2,
        REG_HP_A1 = 3'd3,
        REG_LP_B0 = 3'd4,
        REG_LP_B1 = 3'd5,
        REG_LP_A1 = 3'd6
    } reg_idx_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_val_t;

    typedef struct packed {
        coef_val_t hp_b0;
        coef_val_t hp_b1;
        coef_val_t hp_a1;
        coef_val_t lp_b0;
        coef_val_t lp_b1;
        coef_val_t lp_a1;
    } coef_t;

    typedef struct packed {
        sample_t sample_x;
        sample_t sample_y;
        sample_t sample_z;
    } in_t;

    typedef struct packed {
        sample_t hp_x;
        sample_t hp_y;
        sample_t hp_z;
        sample_t lp_x;
        sample_t lp_y;
        sample_t lp_z;
    } out_t;

    // Lane handshake with the top level
    typedef struct packed {
        logic start;
        logic drain;
    } lane_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } lane_stat_t;

    typedef struct packed {
        sample_t hp;
        sample_t lp;
    } lane_res_t;

    // Arithmetic shift by the coefficient fraction, then clamp to the sample range
    function automatic sample_t scale_sat(input logic signed [ACC_BITS-1:0] acc);
        logic signed [ACC_BITS-1:0] sh;
        logic signed [ACC_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0] lo;
        sh = acc >>> COEF_FRAC_BITS;
        hi = {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
        lo = ~hi;
        if (sh > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (sh < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return sh[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/iir3ax_lane.sv -----
// One axis lane: filter state and a shared first-order section stepped by a small sequencer.
module iir3ax_lane import iir3ax_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  mode_t      mode,
    input  coef_t      coef,
    input  lane_ctl_t  ctl,
    input  sample_t    x_in,
    output lane_stat_t stat,
    output lane_res_t  res
);

    typedef enum logic [5:0] {
        L_IDLE  = 6'b000001,
        L_MUL_A = 6'b000010,
        L_SUM_A = 6'b000100,
        L_MUL_B = 6'b001000,
        L_SUM_B = 6'b010000,
        L_DONE  = 6'b100000
    } lane_phase_t;

    lane_phase_t phase_reg, phase_next;

    sample_t x_reg;
    sample_t prev_raw_reg, prev_raw_next;
    sample_t prev_hp_reg, prev_hp_next;
    sample_t prev_lp_reg, prev_lp_next;
    sample_t hp_reg, hp_next;
    sample_t lp_reg, lp_next;

    logic signed [PROD_BITS-1:0] p0_reg, p1_reg, p2_reg;

    coef_val_t c0, c1, c2;
    sample_t   d0, d1, d2;
    logic signed [ACC_BITS-1:0] acc;
    sample_t   sec_out;

    // Multiplier operands: first pass is the high-pass section (or low-pass alone),
    // second pass is the low-pass half of the bandpass cascade
    always_comb begin
        if (phase_reg == L_MUL_B) begin
            c0 = coef.lp_b0;  d0 = hp_reg;
            c1 = coef.lp_b1;  d1 = prev_hp_reg;
            c2 = coef.lp_a1;  d2 = prev_lp_reg;
        end else if (mode == MODE_LP_ONLY) begin
            c0 = coef.lp_b0;  d0 = x_reg;
            c1 = coef.lp_b1;  d1 = prev_raw_reg;
            c2 = coef.lp_a1;  d2 = prev_lp_reg;
        end else begin
            c0 = coef.hp_b0;  d0 = x_reg;
            c1 = coef.hp_b1;  d1 = prev_raw_reg;
            c2 = coef.hp_a1;  d2 = prev_hp_reg;
        end
    end

    // Registered products
    always_ff @(posedge aclk) begin
        if (phase_reg == L_MUL_A || phase_reg == L_MUL_B) begin
            p0_reg <= PROD_BITS'(c0 * d0);
            p1_reg <= PROD_BITS'(c1 * d1);
            p2_reg <= PROD_BITS'(c2 * d2);
        end
    end

    // Section sum, scaling and clamp
    always_comb begin
        acc = {{2{p0_reg[PROD_BITS-1]}}, p0_reg}
            + {{2{p1_reg[PROD_BITS-1]}}, p1_reg}
            - {{2{p2_reg[PROD_BITS-1]}}, p2_reg};
        sec_out = scale_sat(acc);
    end

    // Sequencer
    always_comb begin
        phase_next    = phase_reg;
        hp_next       = hp_reg;
        lp_next       = lp_reg;
        prev_raw_next = prev_raw_reg;
        prev_hp_next  = prev_hp_reg;
        prev_lp_next  = prev_lp_reg;
        unique case (phase_reg)
            L_IDLE: begin
                if (ctl.start) begin
                    phase_next = L_MUL_A;
                end
            end
            L_MUL_A: begin
                phase_next = L_SUM_A;
            end
            L_SUM_A: begin
                hp_next    = prev_hp_reg;
                lp_next    = prev_lp_reg;
                phase_next = L_DONE;
                case (mode)
                    MODE_BANDPASS: begin
                        hp_next    = sec_out;
                        phase_next = L_MUL_B;
                    end
                    MODE_HP_ONLY: hp_next = sec_out;
                    MODE_LP_ONLY: lp_next = sec_out;
                    default: ;
                endcase
            end
            L_MUL_B: begin
                phase_next = L_SUM_B;
            end
            L_SUM_B: begin
                lp_next    = sec_out;
                phase_next = L_DONE;
            end
            L_DONE: begin
                // result handed off: commit history, optionally take the next beat
                if (ctl.drain) begin
                    prev_raw_next = x_reg;
                    prev_hp_next  = hp_reg;
                    prev_lp_next  = lp_reg;
                    phase_next    = ctl.start ? L_MUL_A : L_IDLE;
                end
            end
            default: phase_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= L_IDLE;
            prev_raw_reg <= '0;
            prev_hp_reg  <= '0;
            prev_lp_reg  <= '0;
        end else begin
            phase_reg    <= phase_next;
            prev_raw_reg <= prev_raw_next;
            prev_hp_reg  <= prev_hp_next;
            prev_lp_reg  <= prev_lp_next;
        end
    end

    always_ff @(posedge aclk) begin
        hp_reg <= hp_next;
        lp_reg <= lp_next;
        if (ctl.start) begin
            x_reg <= x_in;
        end
    end

    assign stat.idle = (phase_reg == L_IDLE);
    assign stat.done = (phase_reg == L_DONE);
    assign res.hp    = hp_reg;
    assign res.lp    = lp_reg;

endmodule

// ----- rtl/core/iir3ax_merge.sv -----
// Merge stage: gathers the lane results into one result beat held in the output register.
module iir3ax_merge import iir3ax_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  lane_res_t lane_res [AXES],
    input  logic      all_done,
    output logic      drain,
    output logic      m_valid,
    input  logic      m_ready,
    output out_t      m_data
);

    logic m_valid_reg, m_valid_next;
    out_t data_reg;

    // Lanes hand off when the output register is empty or being emptied
    assign drain = all_done && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (drain) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            data_reg.hp_x <= lane_res[0].hp;
            data_reg.hp_y <= lane_res[1].hp;
            data_reg.hp_z <= lane_res[2].hp;
            data_reg.lp_x <= lane_res[0].lp;
            data_reg.lp_y <= lane_res[1].lp;
            data_reg.lp_z <= lane_res[2].lp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = data_reg;

endmodule

// ----- rtl/core/three_axis_first_order_iir_filter.sv -----
// Three-axis first-order IIR filter (bandpass, high-pass or low-pass): config and lanes.
// Each lane steps its one section unit (three multipliers, one adder) through a multiply
// phase and a sum phase per pass: twice in bandpass mode, once in the other modes.
// A lane takes a new beat only when idle or as its result moves to the output register.
// A finished result waits in the output register while the next beat is processed.
// Reset (aresetn low, synchronous) clears the config registers, filter history and the output valid.
module three_axis_first_order_iir_filter import iir3ax_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]    cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  in_t                     s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output out_t                    m_data
);

    mode_t mode_reg;
    coef_t coef_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BANDPASS;
            coef_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:  mode_reg       <= mode_t'(cfg_wdata[1:0]);
                REG_HP_B0: coef_reg.hp_b0 <= cfg_wdata;
                REG_HP_B1: coef_reg.hp_b1 <= cfg_wdata;
                REG_HP_A1: coef_reg.hp_a1 <= cfg_wdata;
                REG_LP_B0: coef_reg.lp_b0 <= cfg_wdata;
                REG_LP_B1: coef_reg.lp_b1 <= cfg_wdata;
                REG_LP_A1: coef_reg.lp_a1 <= cfg_wdata;
                default: ;
            endcase
        end
    end

    sample_t    samples [AXES];
    lane_stat_t stat [AXES];
    lane_res_t  res [AXES];
    logic [AXES-1:0] lane_free;
    logic [AXES-1:0] lane_done;
    logic       drain;
    lane_ctl_t  ctl;

    assign samples[0] = s_data.sample_x;
    assign samples[1] = s_data.sample_y;
    assign samples[2] = s_data.sample_z;

    // A lane can take a beat when idle or when its result is leaving this cycle
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            lane_free[i] = stat[i].idle || (stat[i].done && drain);
            lane_done[i] = stat[i].done;
        end
    end

    assign s_ready   = &lane_free;
    assign ctl.start = s_valid && s_ready;
    assign ctl.drain = drain;

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        iir3ax_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .mode    (mode_reg),
            .coef    (coef_reg),
            .ctl     (ctl),
            .x_in    (samples[g]),
            .stat    (stat[g]),
            .res     (res[g])
        );
    end

    iir3ax_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lane_res (res),
        .all_done (&lane_done),
        .drain    (drain),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- sim/iir3ax_filter_checker.sv -----
// Output checker for the three-axis IIR filter: tracks config, predicts each result beat, compares.
`timescale 1ns / 100ps

module iir3ax_filter_checker import iir3ax_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]    cfg_wdata,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  in_t                     s_data,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  out_t                    m_data,
    output int                      fail_count,
    output int                      results_done
);

    localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    // Shadow of the register file and the per-axis filter history
    mode_t   cur_mode;
    coef_t   coefs;
    sample_t raw_hist [AXES];
    sample_t hp_hist  [AXES];
    sample_t lp_hist  [AXES];

    // Filtered vectors still owed by the block, oldest first
    out_t    pending_results [$];

    // One first-order section: exact sum, floor shift, clamp to the sample range
    function automatic sample_t iir_section(input sample_t x, input sample_t x_prev,
                                            input sample_t y_prev, input coef_val_t b0,
                                            input coef_val_t b1, input coef_val_t a1);
        longint acc;
        acc = longint'(b0) * longint'(x) + longint'(b1) * longint'(x_prev)
              - longint'(a1) * longint'(y_prev);
        acc = acc >>> COEF_FRAC_BITS;
        if (acc > OUT_MAX) acc = OUT_MAX;
        if (acc < OUT_MIN) acc = OUT_MIN;
        return sample_t'(acc);
    endfunction

    // Advance all three axes by one sample and return both filtered vectors
    function automatic out_t filter_step(input in_t samp);
        sample_t raw [AXES];
        sample_t hp_now [AXES];
        sample_t lp_now [AXES];
        out_t    res;
        raw[0] = samp.sample_x;
        raw[1] = samp.sample_y;
        raw[2] = samp.sample_z;
        for (int a = 0; a < AXES; a++) begin
            hp_now[a] = hp_hist[a];
            lp_now[a] = lp_hist[a];
            case (cur_mode)
                MODE_BANDPASS: begin
                    // low-pass stage takes the fresh and the stored high-pass values
                    hp_now[a] = iir_section(raw[a], raw_hist[a], hp_hist[a],
                                            coefs.hp_b0, coefs.hp_b1, coefs.hp_a1);
                    lp_now[a] = iir_section(hp_now[a], hp_hist[a], lp_hist[a],
                                            coefs.lp_b0, coefs.lp_b1, coefs.lp_a1);
                end
                MODE_HP_ONLY: begin
                    hp_now[a] = iir_section(raw[a], raw_hist[a], hp_hist[a],
                                            coefs.hp_b0, coefs.hp_b1, coefs.hp_a1);
                end
                MODE_LP_ONLY: begin
                    lp_now[a] = iir_section(raw[a], raw_hist[a], lp_hist[a],
                                            coefs.lp_b0, coefs.lp_b1, coefs.lp_a1);
                end
                default: begin
                    // no section runs, both outputs repeat
                end
            endcase
            raw_hist[a] = raw[a];
            hp_hist[a]  = hp_now[a];
            lp_hist[a]  = lp_now[a];
        end
        res.hp_x = hp_now[0];
        res.hp_y = hp_now[1];
        res.hp_z = hp_now[2];
        res.lp_x = lp_now[0];
        res.lp_y = lp_now[1];
        res.lp_z = lp_now[2];
        return res;
    endfunction

    function automatic void check_field(input string name, input sample_t want,
                                        input sample_t got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            cur_mode = MODE_BANDPASS;
            coefs    = '0;
            for (int a = 0; a < AXES; a++) begin
                raw_hist[a] = '0;
                hp_hist[a]  = '0;
                lp_hist[a]  = '0;
            end
            pending_results.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MODE:  cur_mode    = mode_t'(cfg_wdata[1:0]);
                    REG_HP_B0: coefs.hp_b0 = cfg_wdata;
                    REG_HP_B1: coefs.hp_b1 = cfg_wdata;
                    REG_HP_A1: coefs.hp_a1 = cfg_wdata;
                    REG_LP_B0: coefs.lp_b0 = cfg_wdata;
                    REG_LP_B1: coefs.lp_b1 = cfg_wdata;
                    REG_LP_A1: coefs.lp_a1 = cfg_wdata;
                    default: ;
                endcase
            end

            // result beat against the oldest prediction
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no sample outstanding");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("hp_x", want.hp_x, m_data.hp_x);
                    check_field("hp_y", want.hp_y, m_data.hp_y);
                    check_field("hp_z", want.hp_z, m_data.hp_z);
                    check_field("lp_x", want.lp_x, m_data.lp_x);
                    check_field("lp_y", want.lp_y, m_data.lp_y);
                    check_field("lp_z", want.lp_z, m_data.lp_z);
                end
                results_done <= results_done + 1;
            end

            // sample beat: predict its result
            if (s_valid && s_ready) begin
                pending_results.push_back(filter_step(s_data));
            end
        end
    end

endmodule

// ----- sim/three_axis_first_order_iir_filter_tb.sv -----
// Stimulus and verdict for the three-axis IIR filter: directed corners, then random phases.
`timescale 1ns / 100ps

module three_axis_first_order_iir_filter_tb;
    import iir3ax_pkg::*;

    localparam int      RESET_CYCLES    = 6;
    localparam int      SETTLE_CYCLES   = 10;
    localparam int      RAND_PHASES     = 12;
    localparam int      ITEMS_PER_PHASE = 125;
    localparam int      CYCLE_LIMIT     = 500000;
    localparam int      COEF_MAX        = (1 <<< (COEF_BITS - 1)) - 1;
    localparam int      COEF_MIN        = -COEF_MAX - 1;
    localparam sample_t SAMPLE_MAX      = sample_t'((1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam sample_t SAMPLE_MIN      = sample_t'(-(1 <<< (SAMPLE_BITS - 1)));

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [COEF_BITS-1:0]    cfg_wdata = '0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    in_t                     s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    out_t                    m_data;

    int fail_count;
    int results_done;
    int items_sent  = 0;
    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    bit no_idle     = 1'b0;

    always #10 aclk = ~aclk;

    three_axis_first_order_iir_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    iir3ax_filter_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .results_done (results_done)
    );

    // Result side: ready drops in random bursts
    initial begin
        @(posedge aclk);
        forever begin
            if (!no_idle && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("three_axis_first_order_iir_filter_tb: FAIL");
        $finish;
    end

    task automatic wait_drained();
        while (results_done < items_sent) @(posedge aclk);
    endtask

    // One sample beat, with an optional gap in front of it
    task automatic send_sample(input sample_t x, input sample_t y, input sample_t z);
        if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
            // now and then hold off until the pipe is empty
            if ($urandom_range(0, 99) == 0) wait_drained();
        end
        s_valid         <= 1'b1;
        s_data.sample_x <= x;
        s_data.sample_y <= y;
        s_data.sample_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [COEF_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Reprogram every register once the block has gone quiet
    task automatic load_config(input mode_t mode, input coef_t c);
        s_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_MODE, {{(COEF_BITS-2){1'b0}}, mode});
        write_reg(REG_HP_B0, c.hp_b0);
        write_reg(REG_HP_B1, c.hp_b1);
        write_reg(REG_HP_A1, c.hp_a1);
        write_reg(REG_LP_B0, c.lp_b0);
        write_reg(REG_LP_B1, c.lp_b1);
        write_reg(REG_LP_A1, c.lp_a1);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic coef_t make_coefs(input int hb0, input int hb1, input int ha1,
                                         input int lb0, input int lb1, input int la1);
        coef_t c;
        c.hp_b0 = coef_val_t'(hb0);
        c.hp_b1 = coef_val_t'(hb1);
        c.hp_a1 = coef_val_t'(ha1);
        c.lp_b0 = coef_val_t'(lb0);
        c.lp_b1 = coef_val_t'(lb1);
        c.lp_a1 = coef_val_t'(la1);
        return c;
    endfunction

    // tame: stable filter gains; otherwise corners and raw bit patterns
    function automatic coef_val_t pick_coef(input bit tame);
        if (tame) return coef_val_t'(int'($urandom_range(0, 30000)) - 15000);
        case ($urandom_range(0, 3))
            0:       return coef_val_t'(COEF_MAX);
            1:       return coef_val_t'(COEF_MIN);
            2:       return '0;
            default: return coef_val_t'($urandom);
        endcase
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1:       return sample_t'(int'($urandom_range(0, 512)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    initial begin
        mode_t mode;
        coef_t c;
        bit    tame;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        gap_pct   = 20;
        stall_pct = 20;

        // reset settings: all gains zero, both vectors stay at zero
        send_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(0));
        send_sample(sample_t'(-1), sample_t'(1), SAMPLE_MIN);

        // moderate bandpass cascade on full-scale steps
        load_config(MODE_BANDPASS, make_coefs(16000, -16000, -15000, 2000, 2000, -12384));
        send_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(0));
        send_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(0));
        send_sample(SAMPLE_MIN, SAMPLE_MAX, sample_t'(-1));
        send_sample(SAMPLE_MIN, SAMPLE_MAX, sample_t'(1));
        send_sample(sample_t'(0), sample_t'(0), sample_t'(0));
        send_sample(sample_t'(-1), sample_t'(-1), sample_t'(-1));

        // high-pass only with corner gains: saturates both ways, low-pass held
        load_config(MODE_HP_ONLY, make_coefs(COEF_MAX, COEF_MIN, COEF_MAX, 0, 0, 0));
        send_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(1));
        send_sample(SAMPLE_MIN, SAMPLE_MAX, sample_t'(-1));
        send_sample(SAMPLE_MAX, sample_t'(0), SAMPLE_MIN);
        send_sample(sample_t'(0), sample_t'(-1), sample_t'(0));
        send_sample(sample_t'(-1), sample_t'(1), SAMPLE_MAX);

        // low-pass only with opposite corners, high-pass held
        load_config(MODE_LP_ONLY, make_coefs(0, 0, 0, COEF_MIN, COEF_MAX, COEF_MIN));
        send_sample(SAMPLE_MIN, SAMPLE_MAX, sample_t'(0));
        send_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(-1));
        send_sample(sample_t'(1), sample_t'(-1), SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);

        // unused selector: nothing runs, raw history still advances
        load_config(MODE_NONE, make_coefs(COEF_MAX, COEF_MAX, COEF_MAX,
                                          COEF_MAX, COEF_MAX, COEF_MAX));
        send_sample(sample_t'(12345), sample_t'(-23456), SAMPLE_MAX);
        send_sample(SAMPLE_MIN, sample_t'(0), sample_t'(-1));
        send_sample(sample_t'(-7), sample_t'(7), sample_t'(0));

        // bandpass with every gain at a corner, fed from the history left above
        load_config(MODE_BANDPASS, make_coefs(COEF_MIN, COEF_MAX, COEF_MIN,
                                              COEF_MAX, COEF_MIN, COEF_MAX));
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MIN, sample_t'(-1), SAMPLE_MAX);
        send_sample(sample_t'(0), SAMPLE_MIN, sample_t'(1));
        send_sample(sample_t'(-1), SAMPLE_MAX, sample_t'(0));

        // random phases, each with fresh settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 3) begin
                mode = mode_t'(p);
            end else begin
                mode = ($urandom_range(0, 7) == 0) ? MODE_NONE : mode_t'($urandom_range(0, 2));
            end
            tame    = ($urandom_range(0, 2) != 0);
            c.hp_b0 = pick_coef(tame);
            c.hp_b1 = pick_coef(tame);
            c.hp_a1 = pick_coef(tame);
            c.lp_b0 = pick_coef(tame);
            c.lp_b1 = pick_coef(tame);
            c.lp_a1 = pick_coef(tame);
            load_config(mode, c);
            gap_pct   = 25 * $urandom_range(0, 2);
            stall_pct = 25 * $urandom_range(0, 2);
            no_idle   = (p == RAND_PHASES - 1);
            repeat (ITEMS_PER_PHASE) send_sample(pick_sample(), pick_sample(), pick_sample());
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("three_axis_first_order_iir_filter_tb: PASS");
        end else begin
            $display("three_axis_first_order_iir_filter_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/iir3ax_pkg.sv
rtl/core/iir3ax_lane.sv
rtl/core/iir3ax_merge.sv
rtl/core/three_axis_first_order_iir_filter.sv
sim/iir3ax_filter_checker.sv
sim/three_axis_first_order_iir_filter_tb.sv
